/* hw/rtl/lcoc_pkg.sv */
// Package for the lidar corridor obstacle check: payload structs, config
// struct, codes and queue sizing. No dependencies.
`default_nettype none

package lcoc_pkg;

    // Queue between the front pipeline and the result stage
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Reset value of check_distance, also the reset of both running minima
    localparam logic [15:0] CHECK_DIST_RESET = 16'd3840;
    localparam logic [15:0] CORR_WIDTH_RESET = 16'd256;
    localparam logic [15:0] COS_RESET        = 16'd16384;

    // Configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_COS         = 3'd2;
    localparam logic [2:0] REG_SIN         = 3'd3;
    localparam logic [2:0] REG_CHECK_DIST  = 3'd4;
    localparam logic [2:0] REG_CORR_WIDTH  = 3'd5;
    localparam logic [2:0] REG_SIDE_OFFSET = 3'd6;
    localparam logic [2:0] REG_DYN_MISSION = 3'd7;

    // Corridor hit codes
    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_OWN  = 2'd1;
    localparam logic [1:0] HIT_SIDE = 2'd2;

    // Safe lane codes
    localparam logic [1:0] LANE_LEFT  = 2'd0;
    localparam logic [1:0] LANE_MID   = 2'd1;
    localparam logic [1:0] LANE_RIGHT = 2'd2;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic        marked;
        logic [1:0]  corridor_hit;
        logic        scan_done;
        logic [1:0]  free_lane;
        logic        dyn_alert;
        logic [15:0] nearest_own;
        logic [15:0] nearest_side;
    } result_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [15:0] heading_cosine;
        logic signed [15:0] heading_sine;
        logic        [15:0] check_distance;
        logic        [15:0] corridor_width;
        logic signed [16:0] side_lane_offset;
        logic               dynamic_mission;
    } cfg_t;

    // One classified point, as it travels through the queue
    typedef struct packed {
        logic [1:0]  hit;
        logic [15:0] fwd_dist;
        logic        last;
    } qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

`default_nettype wire

/* hw/rtl/lcoc_front.sv */
// Front pipeline: translate, rotate and classify one point per cycle.
// Depends on lcoc_pkg.
`default_nettype none

module lcoc_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire lcoc_pkg::point_t in_data,
    input  wire lcoc_pkg::cfg_t  cfg,
    output logic                 push,
    output lcoc_pkg::qent_t      push_data
);
    import lcoc_pkg::*;

    // stage 0: translated point
    logic               v0_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic               last0_reg;
    // stage 1: partial products
    logic               v1_reg;
    logic signed [48:0] cdx_reg, sdy_reg, cdy_reg, sdx_reg;
    logic               last1_reg;
    // stage 2: rotated point, units of 2^-22 m
    logic               v2_reg;
    logic signed [49:0] xr_reg, yr_reg;
    logic               last2_reg;
    // stage 3: classified entry
    logic               v3_reg;
    qent_t              ent_reg;

    logic signed [32:0] dx_next, dy_next;
    logic signed [48:0] cos_ext, sin_ext, dx_ext, dy_ext;
    logic signed [49:0] xr_next, yr_next;
    logic signed [49:0] xlim, ylim, ylim_neg;
    logic signed [50:0] ys, ylim_w, ylim_w_neg;
    logic               in_x, own_y, side_y;
    qent_t              ent_next;

    // translation
    always_comb begin
        dx_next = {in_data.point_x[31], in_data.point_x} - {cfg.origin_x[31], cfg.origin_x};
        dy_next = {in_data.point_y[31], in_data.point_y} - {cfg.origin_y[31], cfg.origin_y};
    end

    // operands widened to the full product width
    always_comb begin
        cos_ext = {{33{cfg.heading_cosine[15]}}, cfg.heading_cosine};
        sin_ext = {{33{cfg.heading_sine[15]}}, cfg.heading_sine};
        dx_ext  = {{16{dx_reg[32]}}, dx_reg};
        dy_ext  = {{16{dy_reg[32]}}, dy_reg};
    end

    // rotation sums
    always_comb begin
        xr_next = {cdx_reg[48], cdx_reg} + {sdy_reg[48], sdy_reg};
        yr_next = {cdy_reg[48], cdy_reg} - {sdx_reg[48], sdx_reg};
    end

    // corridor tests, exact
    always_comb begin
        xlim       = {20'd0, cfg.check_distance, 14'd0};
        ylim       = {21'd0, cfg.corridor_width, 13'd0};
        ylim_neg   = -ylim;
        ylim_w     = {22'd0, cfg.corridor_width, 13'd0};
        ylim_w_neg = -ylim_w;
        ys         = {yr_reg[49], yr_reg} + {{20{cfg.side_lane_offset[16]}},
                                             cfg.side_lane_offset, 14'd0};
        in_x   = !xr_reg[49] && (xr_reg != '0) && (xr_reg < xlim);
        own_y  = (yr_reg < ylim) && (yr_reg > ylim_neg);
        side_y = (ys < ylim_w) && (ys > ylim_w_neg);

        ent_next.last     = last2_reg;
        ent_next.fwd_dist = in_x ? xr_reg[29:14] : 16'd0;
        if (in_x && own_y) begin
            ent_next.hit = HIT_OWN;
        end else if (in_x && !cfg.dynamic_mission && side_y) begin
            ent_next.hit = HIT_SIDE;
        end else begin
            ent_next.hit = HIT_NONE;
        end
    end

    // valid chain; the pipeline never stalls, the credit count upstream
    // guarantees queue room for everything in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        last0_reg <= in_data.last_point;
        cdx_reg   <= cos_ext * dx_ext;
        sdy_reg   <= sin_ext * dy_ext;
        cdy_reg   <= cos_ext * dy_ext;
        sdx_reg   <= sin_ext * dx_ext;
        last1_reg <= last0_reg;
        xr_reg    <= xr_next;
        yr_reg    <= yr_next;
        last2_reg <= last1_reg;
        ent_reg   <= ent_next;
    end

    assign push      = v3_reg;
    assign push_data = ent_reg;

endmodule

`default_nettype wire

/* hw/rtl/lcoc_queue.sv */
// Small register FIFO of classified points between front and back.
// Depends on lcoc_pkg.
`default_nettype none

module lcoc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lcoc_pkg::qent_t push_data,
    input  wire logic            pop,
    output logic                 rd_valid,
    output lcoc_pkg::qent_t      rd_data,
    output lcoc_pkg::qstat_t     stat
);
    import lcoc_pkg::*;

    qent_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign rd_valid   = (count_reg != '0);
    assign rd_data    = mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

/* hw/rtl/lcoc_back.sv */
// Back end: running corridor minima, scan summary and the output register.
// Depends on lcoc_pkg.
`default_nettype none

module lcoc_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire lcoc_pkg::qent_t q_data,
    input  wire lcoc_pkg::cfg_t  cfg,
    output logic                 pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output lcoc_pkg::result_t    m_data
);
    import lcoc_pkg::*;

    logic [15:0] own_min_reg, own_min_next;
    logic [15:0] side_min_reg, side_min_next;
    logic        dyn_seen_reg, dyn_seen_next;
    logic        m_valid_reg;
    result_t     m_data_reg, m_data_next;
    logic [15:0] own_new, side_new;
    logic        dyn_new;

    // take the next entry when the output register is free or draining
    assign pop = q_valid && (!m_valid_reg || m_ready);

    // update minima and build the result
    always_comb begin
        own_new  = own_min_reg;
        side_new = side_min_reg;
        if (q_data.hit == HIT_OWN && q_data.fwd_dist < own_min_reg) begin
            own_new = q_data.fwd_dist;
        end
        if (q_data.hit == HIT_SIDE && q_data.fwd_dist < side_min_reg) begin
            side_new = q_data.fwd_dist;
        end
        dyn_new = dyn_seen_reg || (q_data.hit == HIT_OWN && cfg.dynamic_mission);

        m_data_next.marked       = (q_data.hit != HIT_NONE);
        m_data_next.corridor_hit = q_data.hit;
        m_data_next.scan_done    = q_data.last;
        m_data_next.nearest_own  = own_new;
        m_data_next.nearest_side = side_new;
        m_data_next.free_lane    = LANE_MID;
        m_data_next.dyn_alert    = 1'b0;

        own_min_next  = own_new;
        side_min_next = side_new;
        dyn_seen_next = dyn_new;

        // end of scan: summary, then reload
        if (q_data.last) begin
            if (own_new < side_new) begin
                if (!cfg.side_lane_offset[16] && cfg.side_lane_offset != '0) begin
                    m_data_next.free_lane = LANE_LEFT;
                end else if (cfg.side_lane_offset[16]) begin
                    m_data_next.free_lane = LANE_RIGHT;
                end
            end
            m_data_next.dyn_alert = dyn_new;
            own_min_next  = cfg.check_distance;
            side_min_next = cfg.check_distance;
            dyn_seen_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_min_reg  <= CHECK_DIST_RESET;
            side_min_reg <= CHECK_DIST_RESET;
            dyn_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                own_min_reg  <= own_min_next;
                side_min_reg <= side_min_next;
                dyn_seen_reg <= dyn_seen_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/lidar_corridor_obstacle_check.sv */
// Lidar corridor obstacle check, top level: config registers, credit
// count, front pipeline, queue and back end. Depends on lcoc_pkg,
// lcoc_front, lcoc_queue and lcoc_back.
//
// Usage:
//  - s_valid/s_ready/s_data carry one lidar point per transfer (absolute
//    x, y in Q.8 meters and a last-point flag).
//  - m_valid/m_ready/m_data return exactly one result per point, in order.
//  - cfg_wr_en/cfg_index/cfg_wdata write a config register;
//    write only while no point is outstanding.
//  - A point passes through translate, multiply, sum, classify, the queue
//    and the output register, in that order.
//  - Throughput: one point per cycle while s_ready is high; the four-stage
//    front pipeline feeds an 8-entry queue through a credit count.
//  - When m_ready is low the result holds in the output register; the
//    queue keeps filling and s_ready drops once 8 points are in flight.
//  - Reset (aresetn low, synchronous) restores the config defaults, loads
//    both minima with the default check distance and empties the pipeline.
//  - On the last point of a scan the summary is reported and the minima
//    reload from the current check distance.
`default_nettype none

module lidar_corridor_obstacle_check (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lcoc_pkg::point_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lcoc_pkg::result_t      m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_wdata
);
    import lcoc_pkg::*;

    cfg_t              cfg_reg;
    logic [QCNT_W-1:0] credit_reg, credit_next;
    logic              s_accept;
    logic              push, pop;
    qent_t             push_data, rd_data;
    logic              rd_valid;
    qstat_t            q_stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x         <= '0;
            cfg_reg.origin_y         <= '0;
            cfg_reg.heading_cosine   <= COS_RESET;
            cfg_reg.heading_sine     <= '0;
            cfg_reg.check_distance   <= CHECK_DIST_RESET;
            cfg_reg.corridor_width   <= CORR_WIDTH_RESET;
            cfg_reg.side_lane_offset <= '0;
            cfg_reg.dynamic_mission  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ORIGIN_X:    cfg_reg.origin_x         <= cfg_wdata;
                REG_ORIGIN_Y:    cfg_reg.origin_y         <= cfg_wdata;
                REG_COS:         cfg_reg.heading_cosine   <= cfg_wdata[15:0];
                REG_SIN:         cfg_reg.heading_sine     <= cfg_wdata[15:0];
                REG_CHECK_DIST:  cfg_reg.check_distance   <= cfg_wdata[15:0];
                REG_CORR_WIDTH:  cfg_reg.corridor_width   <= cfg_wdata[15:0];
                REG_SIDE_OFFSET: cfg_reg.side_lane_offset <= cfg_wdata[16:0];
                REG_DYN_MISSION: cfg_reg.dynamic_mission  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // credits: points accepted and not yet moved to the output register
    assign s_ready  = (credit_reg < QCNT_W'(QDEPTH));
    assign s_accept = s_valid && s_ready;

    always_comb begin
        credit_next = credit_reg;
        if (s_accept && !pop) begin
            credit_next = credit_reg + 1'b1;
        end else if (!s_accept && pop) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    lcoc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_accept),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data)
    );

    lcoc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data),
        .stat      (q_stat)
    );

    lcoc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (rd_valid),
        .q_data  (rd_data),
        .cfg     (cfg_reg),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // credit count never runs past the queue depth
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= QCNT_W'(QDEPTH))
        else $error("credit count exceeds queue depth");

    // the credit scheme must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_stat.full && !pop))
        else $error("push into full queue");

    // a pop needs something in the queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // summary fields stay neutral except on the last point
    a_summary_neutral: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.scan_done) |->
            (m_data.free_lane == LANE_MID && !m_data.dyn_alert))
        else $error("summary fields set on a non-final point");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for lidar_corridor_obstacle_check: directed stimulus rows,
// then random scans checked against a built-in corridor predictor.
// Depends on lcoc_pkg and the lidar_corridor_obstacle_check RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcoc_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_POINTS   = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int DIRECTED_ROWS  = 41;
    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // One row of the directed stimulus: either a register write or a point
    typedef struct packed {
        logic        is_write;
        logic [2:0]  reg_index;
        logic [31:0] reg_value;
        point_t      pt;
        logic        pinned;
        result_t     want;
    } stim_row_t;

    // Hand-written expectation travelling alongside a point until its transfer
    typedef struct packed {
        logic    pinned;
        result_t value;
    } pinned_t;

    logic    aclk      = 1'b0;
    logic    aresetn   = 1'b0;
    logic    s_valid   = 1'b0;
    logic    s_ready;
    point_t  s_data    = '0;
    logic    m_valid;
    logic    m_ready   = 1'b0;
    result_t m_data;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    lidar_corridor_obstacle_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Mirror of the register file and the per-scan corridor state
    cfg_t        shadow;
    logic [15:0] own_nearest;
    logic [15:0] side_nearest;
    logic        dyn_seen;

    result_t   pending_results [$];
    pinned_t   pinned_q [$];
    stim_row_t directed_rows [DIRECTED_ROWS];

    int unsigned send_idle_pct = 32;
    int unsigned recv_idle_pct = 72;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int scans_closed   = 0;
    int own_hits       = 0;
    int side_hits      = 0;
    int lane_changes   = 0;
    int dyn_flags      = 0;
    int reg_writes     = 0;

    result_t predicted;
    pinned_t tag;

    always begin
        #6 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Reload of the running minima, as at reset and at the end of a scan
    function automatic void reload_scan();
        own_nearest  = shadow.check_distance;
        side_nearest = shadow.check_distance;
        dyn_seen     = 1'b0;
    endfunction

    // Corridor predictor: rotate the point into the path frame, test both corridors
    // exactly at full precision and update the running minima.
    function automatic result_t classify_point(point_t p);
        longint  dx, dy, xr, yr, ys, xlim, ylim;
        logic    in_x;
        logic [15:0] fwd;
        result_t r;
        dx   = longint'($signed(p.point_x)) - longint'($signed(shadow.origin_x));
        dy   = longint'($signed(p.point_y)) - longint'($signed(shadow.origin_y));
        xr   = longint'($signed(shadow.heading_cosine)) * dx
             + longint'($signed(shadow.heading_sine)) * dy;
        yr   = longint'($signed(shadow.heading_cosine)) * dy
             - longint'($signed(shadow.heading_sine)) * dx;
        xlim = longint'(shadow.check_distance) * 16384;
        ylim = longint'(shadow.corridor_width) * 8192;
        ys   = yr + longint'($signed(shadow.side_lane_offset)) * 16384;
        in_x = (xr > 0) && (xr < xlim);
        fwd  = 16'(xr >>> 14);
        r = '0;
        r.corridor_hit = HIT_NONE;
        r.free_lane    = LANE_MID;
        r.scan_done    = p.last_point;
        if (in_x && ((yr < 0) ? -yr : yr) < ylim) begin
            r.corridor_hit = HIT_OWN;
            if (shadow.dynamic_mission) begin
                dyn_seen = 1'b1;
            end
            if (fwd < own_nearest) begin
                own_nearest = fwd;
            end
        end else if (in_x && !shadow.dynamic_mission && ((ys < 0) ? -ys : ys) < ylim) begin
            r.corridor_hit = HIT_SIDE;
            if (fwd < side_nearest) begin
                side_nearest = fwd;
            end
        end
        r.marked       = (r.corridor_hit != HIT_NONE);
        r.nearest_own  = own_nearest;
        r.nearest_side = side_nearest;
        if (p.last_point) begin
            if (own_nearest < side_nearest) begin
                if ($signed(shadow.side_lane_offset) > 0) begin
                    r.free_lane = LANE_LEFT;
                end else if ($signed(shadow.side_lane_offset) < 0) begin
                    r.free_lane = LANE_RIGHT;
                end
            end
            r.dyn_alert = dyn_seen;
            reload_scan();
        end
        return r;
    endfunction

    function automatic string show(result_t r);
        return $sformatf("mk=%0d hit=%0d done=%0d lane=%0d dyn=%0d own=%0d side=%0d",
                         r.marked, r.corridor_hit, r.scan_done, r.free_lane,
                         r.dyn_alert, r.nearest_own, r.nearest_side);
    endfunction

    task automatic flag_mismatch(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR at cycle %0d: %s", cycle_count, what);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
        end
    endtask

    // Monitor: register writes, point transfers and result transfers, all
    // sampled with their pre-edge values
    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow.origin_x         = '0;
            shadow.origin_y         = '0;
            shadow.heading_cosine   = COS_RESET;
            shadow.heading_sine     = '0;
            shadow.check_distance   = CHECK_DIST_RESET;
            shadow.corridor_width   = CORR_WIDTH_RESET;
            shadow.side_lane_offset = '0;
            shadow.dynamic_mission  = 1'b0;
            reload_scan();
        end else begin
            if (cfg_wr_en) begin
                reg_writes++;
                case (cfg_index)
                    REG_ORIGIN_X:    shadow.origin_x         = cfg_wdata;
                    REG_ORIGIN_Y:    shadow.origin_y         = cfg_wdata;
                    REG_COS:         shadow.heading_cosine   = cfg_wdata[15:0];
                    REG_SIN:         shadow.heading_sine     = cfg_wdata[15:0];
                    REG_CHECK_DIST:  shadow.check_distance   = cfg_wdata[15:0];
                    REG_CORR_WIDTH:  shadow.corridor_width   = cfg_wdata[15:0];
                    REG_SIDE_OFFSET: shadow.side_lane_offset = cfg_wdata[16:0];
                    REG_DYN_MISSION: shadow.dynamic_mission  = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted = classify_point(s_data);
                tag = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
                pending_results.insert(pending_results.size(),
                                       tag.pinned ? tag.value : predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result transfer with nothing expected", '0, m_data);
                end else begin
                    predicted = pending_results.pop_front();
                    results_seen++;
                    if (predicted.corridor_hit == HIT_OWN) own_hits++;
                    if (predicted.corridor_hit == HIT_SIDE) side_hits++;
                    if (predicted.scan_done) scans_closed++;
                    if (predicted.free_lane != LANE_MID) lane_changes++;
                    if (predicted.dyn_alert) dyn_flags++;
                    if (m_data.marked !== predicted.marked
                        || m_data.corridor_hit !== predicted.corridor_hit
                        || m_data.scan_done !== predicted.scan_done
                        || m_data.free_lane !== predicted.free_lane
                        || m_data.dyn_alert !== predicted.dyn_alert
                        || m_data.nearest_own !== predicted.nearest_own
                        || m_data.nearest_side !== predicted.nearest_side) begin
                        flag_mismatch("result field differs", predicted, m_data);
                    end
                end
            end
        end
    end

    // Stimulus row builders
    function automatic result_t outcome(logic [1:0] hit, logic done, logic [1:0] lane,
                                        logic dyn, logic [15:0] own, logic [15:0] side);
        result_t r;
        r.marked       = (hit != HIT_NONE);
        r.corridor_hit = hit;
        r.scan_done    = done;
        r.free_lane    = lane;
        r.dyn_alert    = dyn;
        r.nearest_own  = own;
        r.nearest_side = side;
        return r;
    endfunction

    function automatic stim_row_t write_row(logic [2:0] idx, logic [31:0] val);
        stim_row_t row;
        row = '0;
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic stim_row_t point_row(logic [31:0] x, logic [31:0] y, logic last);
        stim_row_t row;
        row = '0;
        row.pt.point_x    = x;
        row.pt.point_y    = y;
        row.pt.last_point = last;
        return row;
    endfunction

    function automatic stim_row_t pinned_row(logic [31:0] x, logic [31:0] y, logic last,
                                             result_t want);
        stim_row_t row;
        row        = point_row(x, y, last);
        row.pinned = 1'b1;
        row.want   = want;
        return row;
    endfunction

    // Drop valid and wait until every accepted point has its result back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0 || pinned_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One point transfer; returns at the edge that accepted it
    task automatic drive_point(point_t p, logic pin, result_t want);
        pinned_t entry;
        entry.pinned = pin;
        entry.value  = want;
        pinned_q.insert(pinned_q.size(), entry);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    function automatic logic [15:0] rand_check_distance();
        case ($urandom_range(0, 9))
            7:       return 16'd0;
            8:       return 16'hffff;
            9:       return 16'($urandom);
            default: return 16'($urandom_range(64, 4096));
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        case ($urandom_range(0, 9))
            7:       return S32_MAX;
            8:       return S32_MIN;
            9:       return $urandom;
            default: return $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
    endfunction

    // Random register settings; heading mostly a true rotation, sometimes raw
    task automatic shuffle_config(bit all);
        real         ang;
        logic [15:0] cos_v, sin_v, width_v;
        logic [16:0] off_v;
        int          pick;
        pick = $urandom_range(0, 9);
        ang  = (pick < 6) ? $urandom_range(0, 359) * 3.141592653589793 / 180.0
                          : $urandom_range(0, 3) * 3.141592653589793 / 2.0;
        cos_v = 16'(int'($cos(ang) * 16384.0));
        sin_v = 16'(int'($sin(ang) * 16384.0));
        if (pick >= 8) begin
            cos_v = 16'($urandom);
            sin_v = 16'($urandom);
        end
        case ($urandom_range(0, 9))
            7:       width_v = 16'd0;
            8:       width_v = 16'hffff;
            9:       width_v = 16'($urandom);
            default: width_v = 16'($urandom_range(64, 1024));
        endcase
        case ($urandom_range(0, 9))
            5:       off_v = 17'd0;
            6:       off_v = 17'd65535;
            7:       off_v = -17'sd65535;
            8:       off_v = 17'h10000;
            9:       off_v = 17'($urandom);
            default: off_v = $urandom_range(0, 1) ? 17'($urandom_range(128, 1024))
                                                  : -17'($urandom_range(128, 1024));
        endcase
        if (all || $urandom_range(0, 1)) write_reg(REG_ORIGIN_X, rand_origin());
        if (all || $urandom_range(0, 1)) write_reg(REG_ORIGIN_Y, rand_origin());
        if (all || $urandom_range(0, 1)) write_reg(REG_COS, {{16{cos_v[15]}}, cos_v});
        if (all || $urandom_range(0, 1)) write_reg(REG_SIN, {{16{sin_v[15]}}, sin_v});
        if (all || $urandom_range(0, 1)) write_reg(REG_CHECK_DIST, 32'(rand_check_distance()));
        if (all || $urandom_range(0, 1)) write_reg(REG_CORR_WIDTH, 32'(width_v));
        if (all || $urandom_range(0, 1)) write_reg(REG_SIDE_OFFSET, {{15{off_v[16]}}, off_v});
        if (all || $urandom_range(0, 1)) write_reg(REG_DYN_MISSION, 32'($urandom_range(0, 3) == 0));
    endtask

    // Point placed in the path frame near the own or side corridor, then mapped
    // back to absolute coordinates; a few are plain noise
    function automatic point_t corridor_point();
        point_t p;
        longint c, s, cd, hw, off, u, v, dx, dy;
        int     pick;
        c    = longint'($signed(shadow.heading_cosine));
        s    = longint'($signed(shadow.heading_sine));
        cd   = longint'(shadow.check_distance);
        hw   = longint'(shadow.corridor_width) / 2;
        off  = longint'($signed(shadow.side_lane_offset));
        pick = $urandom_range(0, 99);
        p    = '0;
        if (pick < 12) begin
            p.point_x    = $urandom;
            p.point_y    = $urandom;
            p.last_point = ($urandom_range(0, 3) == 0);
            return p;
        end
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
                0:       u = 0;
                1:       u = 1;
                2:       u = cd - 1;
                3:       u = cd;
                default: u = cd + 1;
            endcase
        end else begin
            u = longint'($urandom_range(0, 32'(cd + cd / 4 + 4))) - cd / 8 - 2;
        end
        v = longint'($urandom_range(0, 32'(2 * hw + 4))) - hw - 2;
        if ($urandom_range(0, 4) == 0) begin
            v = ($urandom_range(0, 1) ? hw : -hw) + longint'($urandom_range(0, 2)) - 1;
        end
        if (pick >= 55) begin
            v = v - off;
        end
        dx = (c * u - s * v) / 16384;
        dy = (s * u + c * v) / 16384;
        p.point_x = 32'(longint'($signed(shadow.origin_x)) + dx);
        p.point_y = 32'(longint'($signed(shadow.origin_y)) + dy);
        return p;
    endfunction

    // A scan of random length; some are left open or see a check distance change
    task automatic run_scan();
        int     len, mid;
        bit     open_end;
        point_t p;
        len      = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                               : $urandom_range(1, 24);
        open_end = ($urandom_range(0, 11) == 0);
        mid      = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int k = 0; k < len; k++) begin
            if (k == mid) begin
                write_reg(REG_CHECK_DIST, 32'(rand_check_distance()));
            end
            p = corridor_point();
            if (k == len - 1) begin
                p.last_point = !open_end;
            end
            drive_point(p, 1'b0, '0);
        end
    endtask

    initial begin
        int phase_start;
        directed_rows = '{
            // defaults: own corridor 0..15 m forward, +/-0.5 m wide
            pinned_row(256, 0, 0, outcome(HIT_OWN, 0, LANE_MID, 0, 256, 3840)),
            pinned_row(0, 0, 0, outcome(HIT_NONE, 0, LANE_MID, 0, 256, 3840)),
            pinned_row(3840, 0, 0, outcome(HIT_NONE, 0, LANE_MID, 0, 256, 3840)),
            pinned_row(3839, 0, 0, outcome(HIT_OWN, 0, LANE_MID, 0, 256, 3840)),
            pinned_row(100, 128, 0, outcome(HIT_NONE, 0, LANE_MID, 0, 256, 3840)),
            pinned_row(100, -127, 0, outcome(HIT_OWN, 0, LANE_MID, 0, 100, 3840)),
            pinned_row(S32_MAX, S32_MAX, 1, outcome(HIT_NONE, 1, LANE_MID, 0, 100, 3840)),
            pinned_row(S32_MIN, S32_MIN, 1, outcome(HIT_NONE, 1, LANE_MID, 0, 3840, 3840)),
            pinned_row(1, 0, 1, outcome(HIT_OWN, 1, LANE_MID, 0, 1, 3840)),
            // side lane on the left, nearer obstacle in own lane
            write_row(REG_SIDE_OFFSET, 512),
            pinned_row(500, -512, 0, outcome(HIT_SIDE, 0, LANE_MID, 0, 3840, 500)),
            pinned_row(400, 0, 0, outcome(HIT_OWN, 0, LANE_MID, 0, 400, 500)),
            pinned_row(0, 0, 1, outcome(HIT_NONE, 1, LANE_LEFT, 0, 400, 500)),
            // side lane on the right
            write_row(REG_SIDE_OFFSET, -512),
            point_row(300, 512, 0),
            point_row(200, 0, 1),
            // dynamic mode ignores the side lane and flags own-lane hits
            write_row(REG_DYN_MISSION, 1),
            point_row(300, 512, 0),
            point_row(50, 0, 1),
            write_row(REG_DYN_MISSION, 0),
            // zero-width corridor
            write_row(REG_CORR_WIDTH, 0),
            point_row(100, 0, 1),
            // quarter-turn heading, widest settings, then a mid-scan distance change
            write_row(REG_CORR_WIDTH, 16'hffff),
            write_row(REG_CHECK_DIST, 16'hffff),
            write_row(REG_COS, 0),
            write_row(REG_SIN, 16384),
            point_row(0, 1000, 0),
            write_row(REG_CHECK_DIST, 100),
            point_row(0, 5000, 0),
            point_row(0, 50, 1),
            // extreme origin and out-of-range trig
            write_row(REG_ORIGIN_X, S32_MIN),
            write_row(REG_ORIGIN_Y, S32_MAX),
            write_row(REG_COS, 32'hffff_8000),
            write_row(REG_SIN, 32'hffff_8000),
            write_row(REG_CHECK_DIST, 0),
            point_row(S32_MAX, S32_MIN, 1),
            write_row(REG_CHECK_DIST, 16'hffff),
            write_row(REG_COS, 32767),
            write_row(REG_SIN, 32767),
            write_row(REG_SIDE_OFFSET, 32'hffff_0000),
            point_row(32'hffff_ffff, 32'hffff_ffff, 1)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                foreach (directed_rows[i]) begin
                    if (directed_rows[i].is_write) begin
                        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
                    end else begin
                        drive_point(directed_rows[i].pt, directed_rows[i].pinned,
                                    directed_rows[i].want);
                    end
                end
            end
            phase_start = items_sent;
            shuffle_config(1'b1);
            while (items_sent - phase_start < PHASE_POINTS) begin
                if ($urandom_range(0, 2) == 0) begin
                    shuffle_config(1'b0);
                end
                run_scan();
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        while (pending_results.size() != 0) begin
            flag_mismatch("expected result never arrived", pending_results.pop_front(), '0);
        end

        $display("Sent %0d points and checked %0d results over %0d closed scans, %0d writes.",
                 items_sent, results_seen, scans_closed, reg_writes);
        $display("Own-lane hits %0d, side-lane hits %0d, lane changes %0d, dynamic flags %0d.",
                 own_hits, side_hits, lane_changes, dyn_flags);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
